### rtl/art_record_validator_macros.svh
// Assertion helpers shared by the record validator RTL.
`ifndef ART_RECORD_VALIDATOR_MACROS_SVH
`define ART_RECORD_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ARV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in record validator");

// Next-cycle implication, checked on every rising edge outside reset.
`define ARV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in record validator");

`endif

### rtl/arv_pkg.sv
package arv_pkg;

    // Header layout and fixed contents.
    localparam logic [15:0] HEADER_BYTES   = 16'd32;
    localparam logic [15:0] PALETTE_OFFSET = 16'd4512;
    localparam logic [15:0] PALETTE_WORDS  = 16'd16;
    localparam logic [15:0] PALETTE_END    = PALETTE_OFFSET + 16'(2 * PALETTE_WORDS);

    localparam logic [7:0] MAGIC_0 = 8'h46;
    localparam logic [7:0] MAGIC_1 = 8'h58;
    localparam logic [7:0] MAGIC_2 = 8'h43;
    localparam logic [7:0] MAGIC_3 = 8'h31;

    localparam logic [7:0] DIM_0 = 8'd80;
    localparam logic [7:0] DIM_1 = 8'd112;
    localparam logic [7:0] DIM_2 = 8'd1;
    localparam logic [7:0] DIM_3 = 8'd0;

    localparam logic [7:0]  BYTE_ZERO  = 8'h00;
    localparam logic [7:0]  BYTE_ONES  = 8'hFF;
    localparam logic [15:0] WORD_ONES  = 16'hFFFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = 2'd2;

    localparam logic [15:0] RST_RECORD_SIZE    = 16'd4544;
    localparam logic [15:0] RST_PAYLOAD_SIZE   = 16'd4512;
    localparam logic [15:0] RST_FORMAT_VERSION = 16'd1;

    typedef struct packed {
        logic [15:0] record_size;
        logic [15:0] payload_size;
        logic [15:0] format_version;
    } t_cfg;

    typedef struct packed {
        logic bad;       // this header byte fails its check
        logic load_exp;  // this byte completes the stored CRC word
    } t_hdr_res;

    // CRC-16, MSB first, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### rtl/arv_hdr_check.sv
module arv_hdr_check (
    input  logic [15:0]       i_pos,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_hold,
    input  arv_pkg::t_cfg     i_cfg,
    output arv_pkg::t_hdr_res o_res
);
    import arv_pkg::*;

    logic [15:0] w_word;
    logic [4:0]  w_pos5;
    logic        w_in_hdr;

    assign w_word   = {i_byte, i_hold};
    assign w_pos5   = i_pos[4:0];
    assign w_in_hdr = (i_pos < HEADER_BYTES);

    always_comb begin
        o_res = '0;
        if (w_in_hdr) begin
            case (w_pos5)
                5'd0:  o_res.bad = (i_byte != MAGIC_0);
                5'd1:  o_res.bad = (i_byte != MAGIC_1);
                5'd2:  o_res.bad = (i_byte != MAGIC_2);
                5'd3:  o_res.bad = (i_byte != MAGIC_3);
                5'd5:  o_res.bad = (w_word != i_cfg.format_version);
                5'd7:  o_res.bad = (w_word != i_cfg.record_size);
                5'd12: o_res.bad = (i_byte != DIM_0);
                5'd13: o_res.bad = (i_byte != DIM_1);
                5'd14: o_res.bad = (i_byte != DIM_2);
                5'd15: o_res.bad = (i_byte != DIM_3);
                5'd17: o_res.bad = (w_word != i_cfg.payload_size);
                5'd21: o_res.load_exp = 1'b1;
                // Byte 23 is compared against the CRC word in the top level.
                5'd4, 5'd6, 5'd16, 5'd20, 5'd22, 5'd23: o_res.bad = 1'b0;
                default: begin
                    if (w_pos5 inside {[5'd8:5'd11], [5'd18:5'd19], [5'd28:5'd31]}) begin
                        o_res.bad = (i_byte != BYTE_ZERO);
                    end else if (w_pos5 inside {[5'd24:5'd27]}) begin
                        o_res.bad = (i_byte != BYTE_ONES);
                    end
                end
            endcase
        end
    end

endmodule

### rtl/art_record_validator.sv
// Channel   | Direction | Signals                                  | Word
// ----------+-----------+------------------------------------------+-------------------------
// in        | input     | i_in_valid, o_in_stall                   | i_data_byte, i_start_of_record
// out       | output    | o_out_valid, i_out_stall                 | o_verdict
// cfg       | input     | i_cfg_we, i_cfg_index, i_cfg_data        | write only, no handshake
//
// One input word is taken per clock cycle while o_in_stall is low; a verdict is registered.
// The rate is set by the single byte-wide CRC step and header compare in the check stage.
// Reset is synchronous and active low; it clears the position, CRC and flags at once.
// A verdict that the sink stalls holds the next last byte in the check stage, which in turn
// stalls the input.
// Bytes that produce no verdict pass through without waiting for the output side.
module art_record_validator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_start_of_record,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_verdict,

    input  logic                          i_cfg_we,
    input  logic [arv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import arv_pkg::*;
    `include "art_record_validator_macros.svh"

    // Configuration registers.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_size    <= RST_RECORD_SIZE;
            r_cfg.payload_size   <= RST_PAYLOAD_SIZE;
            r_cfg.format_version <= RST_FORMAT_VERSION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RECORD_SIZE:    r_cfg.record_size    <= i_cfg_data;
                CFG_PAYLOAD_SIZE:   r_cfg.payload_size   <= i_cfg_data;
                CFG_FORMAT_VERSION: r_cfg.format_version <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: one byte held ahead of the check stage.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_sor;

    // Record state, updated once per processed byte.
    logic [15:0] r_pos;
    logic [15:0] r_crc;
    logic [15:0] r_exp;
    logic [7:0]  r_hold;
    logic        r_bad;

    // Result register.
    logic r_out_valid;
    logic r_verdict;

    logic w_in_acc;
    logic w_proc;
    logic w_out_free;

    assign w_out_free = !(r_out_valid && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // A start-of-record byte sees the state as it is right after a restart.
    logic [15:0] w_pos_e;
    logic [15:0] w_crc_e;
    logic [15:0] w_exp_e;
    logic [7:0]  w_hold_e;
    logic        w_bad_e;

    always_comb begin
        w_pos_e  = r_s1_sor ? 16'd0    : r_pos;
        w_crc_e  = r_s1_sor ? CRC_INIT : r_crc;
        w_exp_e  = r_s1_sor ? 16'd0    : r_exp;
        w_hold_e = r_s1_sor ? 8'd0     : r_hold;
        w_bad_e  = r_s1_sor ? 1'b0     : r_bad;
    end

    t_hdr_res w_hdr;

    arv_hdr_check u_hdr_check (
        .i_pos  (w_pos_e),
        .i_byte (r_s1_byte),
        .i_hold (w_hold_e),
        .i_cfg  (r_cfg),
        .o_res  (w_hdr)
    );

    logic [15:0] w_word;
    logic [15:0] w_crc_n;
    logic [15:0] w_exp_n;
    logic [15:0] w_rel;
    logic [15:0] w_last;
    logic        w_cmp_bad;
    logic        w_pal_bad;
    logic        w_bad_n;
    logic        w_bad_f;
    logic        w_is_last;

    always_comb begin
        w_word  = {r_s1_byte, w_hold_e};
        // The CRC covers every byte after the header.
        w_crc_n = (w_pos_e >= HEADER_BYTES) ? crc_byte(w_crc_e, r_s1_byte) : w_crc_e;
        w_exp_n = w_hdr.load_exp ? w_word : w_exp_e;
        // Header byte 23 completes the complement of the stored CRC word.
        w_cmp_bad = (w_pos_e == 16'd23) && ((w_word ^ w_exp_e) != WORD_ONES);

        // Palette words: high byte must have bit 7 clear, first word must be zero.
        w_rel     = w_pos_e - PALETTE_OFFSET;
        w_pal_bad = 1'b0;
        if (w_pos_e >= PALETTE_OFFSET && w_pos_e < PALETTE_END && w_rel[0]) begin
            w_pal_bad = r_s1_byte[7] ||
                        ((w_rel == 16'd1) && ((w_hold_e != 8'd0) || (r_s1_byte != 8'd0)));
        end

        w_bad_n   = w_bad_e || w_hdr.bad || w_cmp_bad || w_pal_bad;
        // A record size of zero wraps to a final position of 65535.
        w_last    = r_cfg.record_size - 16'd1;
        w_is_last = (w_pos_e == w_last);
        w_bad_f   = w_bad_n || (w_crc_n != w_exp_n);
    end

    // Only a byte that ends a record needs room in the result register.
    assign w_proc     = r_s1_valid && (!w_is_last || w_out_free);
    assign o_in_stall = r_s1_valid && !w_proc;

    logic n_s1_valid;
    logic n_out_valid;

    assign n_s1_valid  = w_in_acc || (r_s1_valid && !w_proc);
    assign n_out_valid = (w_proc && w_is_last) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 16'd0;
            r_crc       <= CRC_INIT;
            r_exp       <= 16'd0;
            r_hold      <= 8'd0;
            r_bad       <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (w_proc) begin
                if (w_is_last) begin
                    // Verdict given; the next byte opens a new record.
                    r_pos  <= 16'd0;
                    r_crc  <= CRC_INIT;
                    r_exp  <= 16'd0;
                    r_hold <= 8'd0;
                    r_bad  <= 1'b0;
                end else begin
                    r_pos  <= w_pos_e + 16'd1;
                    r_crc  <= w_crc_n;
                    r_exp  <= w_exp_n;
                    r_hold <= r_s1_byte;
                    r_bad  <= w_bad_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_byte <= i_data_byte;
            r_s1_sor  <= i_start_of_record;
        end
        if (w_proc && w_is_last) begin
            r_verdict <= w_bad_f;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // The CRC must not move while the header is still being read.
    `ARV_ASSERT_IMPL(a_crc_idle_in_hdr, i_clk, i_rst_n, r_pos <= HEADER_BYTES, r_crc == CRC_INIT)
    // Loading a verdict always leaves the position at the start of a record.
    `ARV_ASSERT_NEXT(a_verdict_restarts, i_clk, i_rst_n, w_proc && w_is_last, r_pos == 16'd0)
    // A start byte that does not end the record leaves the position at one.
    `ARV_ASSERT_NEXT(a_sor_restarts, i_clk, i_rst_n, w_proc && r_s1_sor && !w_is_last,
                     r_pos == 16'd1)

endmodule

### tb/tb_art_record_validator.sv
module tb_art_record_validator;
    import arv_pkg::*;

    // This limit sits well above the length of a correct run.
    localparam int CYCLE_LIMIT = 200_000;
    // Least number of bytes streamed by the random part.
    localparam int RANDOM_WORDS = 840;
    // Cycles to wait after the last owed verdict before a register write, so that a byte that
    // produces no verdict has surely left the block.
    localparam int SETTLE_CYCLES = 6;

    // Palette faults that the record builder can plant before it computes the CRC.
    typedef enum {PAL_CLEAN, PAL_FIRST_LOW, PAL_FIRST_HIGH, PAL_HIGH_BIT} t_pal_fault;
    // Shapes of the records in the random part.
    typedef enum {REC_CLEAN, REC_SPOILED, REC_ABORTED, REC_NOISE} t_rec_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_data_byte;
    logic                 i_start_of_record;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_verdict;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    art_record_validator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_start_of_record (i_start_of_record),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_verdict         (o_verdict),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // The testbench's own copy of the registers, updated whenever one is written.
    logic [15:0] cfg_rec_size = RST_RECORD_SIZE;
    logic [15:0] cfg_payload  = RST_PAYLOAD_SIZE;
    logic [15:0] cfg_version  = RST_FORMAT_VERSION;

    // The tracked record state: position, running CRC, the CRC word taken from the header,
    // the previous byte (the low half of a little-endian word) and the sticky failure flag.
    logic [15:0] trk_pos;
    logic [15:0] trk_crc;
    logic [15:0] trk_check;
    logic [7:0]  trk_hold;
    logic        trk_bad;

    // Verdicts that the block still owes, oldest first.
    logic verdict_due[$];

    // The record being streamed. It holds up to a 65536-byte record.
    logic [7:0] rec_buf [0:65535];
    int         rec_len;

    int    burst_left = 0;
    int    words_sent = 0;
    int    fail_count = 0;
    longint cycle_count = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bitwise CRC-16 with polynomial 0x1021, MSB first. The feedback bit is the top of the
    // register XORed with the incoming data bit.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Register values are biased toward the ends of their range.
    function automatic logic [15:0] pick_register_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic restart_tracker();
        trk_pos   = 16'd0;
        trk_crc   = CRC_INIT;
        trk_check = 16'd0;
        trk_hold  = 8'd0;
        trk_bad   = 1'b0;
    endtask

    // Advances the tracked record by one accepted byte. When the byte is the last one of
    // the record, the verdict that the block must give is queued.
    task automatic judge_byte(input logic [7:0] b, input logic sor);
        logic [15:0] p;
        logic [15:0] word;
        logic [15:0] last_pos;
        if (sor) begin
            restart_tracker();
        end
        p        = trk_pos;
        word     = {b, trk_hold};
        last_pos = cfg_rec_size - 16'd1;

        if (p < HEADER_BYTES) begin
            case (p)
                16'd0: if (b != MAGIC_0) trk_bad = 1'b1;
                16'd1: if (b != MAGIC_1) trk_bad = 1'b1;
                16'd2: if (b != MAGIC_2) trk_bad = 1'b1;
                16'd3: if (b != MAGIC_3) trk_bad = 1'b1;
                16'd5: if (word != cfg_version) trk_bad = 1'b1;
                16'd7: if (word != cfg_rec_size) trk_bad = 1'b1;
                16'd12: if (b != DIM_0) trk_bad = 1'b1;
                16'd13: if (b != DIM_1) trk_bad = 1'b1;
                16'd14: if (b != DIM_2) trk_bad = 1'b1;
                16'd15: if (b != DIM_3) trk_bad = 1'b1;
                16'd17: if (word != cfg_payload) trk_bad = 1'b1;
                16'd21: trk_check = word;
                16'd23: if ((word ^ trk_check) != WORD_ONES) trk_bad = 1'b1;
                16'd8, 16'd9, 16'd10, 16'd11, 16'd18, 16'd19,
                16'd28, 16'd29, 16'd30, 16'd31: if (b != BYTE_ZERO) trk_bad = 1'b1;
                16'd24, 16'd25, 16'd26, 16'd27: if (b != BYTE_ONES) trk_bad = 1'b1;
                default: ;
            endcase
        end else begin
            trk_crc = crc_step(trk_crc, b);
        end

        // Palette words are checked on their high byte. The first word must be zero.
        if (p >= PALETTE_OFFSET && p < PALETTE_END && p[0]) begin
            if (b[7]) begin
                trk_bad = 1'b1;
            end
            if (p == PALETTE_OFFSET + 16'd1 && word != 16'h0000) begin
                trk_bad = 1'b1;
            end
        end

        trk_hold = b;

        if (p == last_pos) begin
            if (trk_crc != trk_check) begin
                trk_bad = 1'b1;
            end
            verdict_due.push_back(trk_bad);
            restart_tracker();
        end else begin
            trk_pos = p + 16'd1;
        end
    endtask

    // Sends one word. The sender works in bursts of random length. Between bursts, valid
    // drops for a random number of cycles, and sometimes not at all. The word is held until
    // the block takes it.
    task automatic send_word(input logic [7:0] b, input logic sor);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 4 : 64);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_data_byte       <= b;
        i_start_of_record <= sor;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        judge_byte(b, sor);
        words_sent++;
    endtask

    // Stops the sender and waits until every owed verdict has come out. It then waits longer,
    // because bytes that end no record still need to leave the block.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (verdict_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RECORD_SIZE:    cfg_rec_size = value;
            CFG_PAYLOAD_SIZE:   cfg_payload  = value;
            CFG_FORMAT_VERSION: cfg_version  = value;
            default: ;
        endcase
    endtask

    // Writes all three registers while the block is idle.
    task automatic load_config(input logic [15:0] rs, input logic [15:0] ps,
                               input logic [15:0] fv);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RECORD_SIZE;
        i_cfg_data  <= rs;
        @(negedge i_clk);
        i_cfg_index <= CFG_PAYLOAD_SIZE;
        i_cfg_data  <= ps;
        @(negedge i_clk);
        i_cfg_index <= CFG_FORMAT_VERSION;
        i_cfg_data  <= fv;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_rec_size = rs;
        cfg_payload  = ps;
        cfg_version  = fv;
    endtask

    // Builds a well-formed record for the current registers in rec_buf. The payload is
    // random, the palette is legal apart from the fault asked for, and the header carries
    // the CRC of everything after it together with its complement. A record_size of zero
    // means a 65536-byte record.
    task automatic build_record(input t_pal_fault fault);
        logic [0:31][7:0] hdr;
        logic [15:0]      crc;
        int               pos;
        rec_len = (cfg_rec_size == 16'd0) ? 65536 : int'(cfg_rec_size);
        for (int i = 0; i < rec_len; i++) begin
            rec_buf[i] = 8'($urandom);
        end

        hdr = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3,
               cfg_version[7:0], cfg_version[15:8],
               cfg_rec_size[7:0], cfg_rec_size[15:8],
               {4{BYTE_ZERO}},
               DIM_0, DIM_1, DIM_2, DIM_3,
               cfg_payload[7:0], cfg_payload[15:8],
               {6{BYTE_ZERO}},
               {4{BYTE_ONES}},
               {4{BYTE_ZERO}}};
        for (int i = 0; i < 32; i++) begin
            rec_buf[i] = hdr[i];
        end

        // The first palette word is zero. Every other word has bit 15 clear.
        for (int i = 0; i < 32; i++) begin
            pos = int'(PALETTE_OFFSET) + i;
            if (i < 2) begin
                rec_buf[pos] = 8'h00;
            end else if (i % 2 == 1) begin
                rec_buf[pos][7] = 1'b0;
            end
        end
        case (fault)
            PAL_FIRST_LOW:  rec_buf[PALETTE_OFFSET] = 8'($urandom_range(1, 255));
            PAL_FIRST_HIGH: rec_buf[PALETTE_OFFSET + 1] = 8'($urandom_range(1, 127));
            PAL_HIGH_BIT:   rec_buf[PALETTE_OFFSET + 2 * $urandom_range(1, 15) + 1][7] = 1'b1;
            default: ;
        endcase

        // Bytes past the end are written too, but they are never sent.
        crc = CRC_INIT;
        for (int i = 32; i < rec_len; i++) begin
            crc = crc_step(crc, rec_buf[i]);
        end
        rec_buf[20] = crc[7:0];
        rec_buf[21] = crc[15:8];
        rec_buf[22] = ~crc[7:0];
        rec_buf[23] = ~crc[15:8];
    endtask

    // Streams the first count bytes of rec_buf. Only the first byte may carry the start flag.
    task automatic stream_record(input logic sor_first, input int count);
        for (int i = 0; i < count; i++) begin
            send_word(rec_buf[i], (i == 0) ? sor_first : 1'b0);
        end
    endtask

    // Only the record size is written, so the payload size and format version keep their
    // reset values. The second record has no start flag, so it relies on the block
    // restarting by itself after a verdict.
    task automatic test_reset_config();
        write_register(CFG_RECORD_SIZE, 16'd40);
        build_record(PAL_CLEAN);
        stream_record(1'b1, rec_len);
        build_record(PAL_CLEAN);
        stream_record(1'b0, rec_len);
    endtask

    // Records shorter than the header. A 24-byte record is complete enough to pass. A
    // start flag in the middle of a record drops that record without a verdict. Records of
    // 3 bytes and 1 byte end before the CRC word arrives, so they must fail.
    task automatic test_short_records();
        load_config(16'd24, 16'($urandom), 16'($urandom));
        build_record(PAL_CLEAN);
        stream_record(1'b1, 24);
        stream_record(1'b1, 10);
        rec_buf[2] = rec_buf[2] ^ 8'h01;
        stream_record(1'b1, 24);

        load_config(16'd3, 16'($urandom), 16'($urandom));
        build_record(PAL_CLEAN);
        stream_record(1'b1, 3);

        load_config(16'd1, 16'($urandom), 16'($urandom));
        send_word(8'($urandom), 1'b1);
        send_word(8'($urandom), 1'b0);
    endtask

    // The payload size and format version at the ends of their range, with records one
    // byte past the header and exactly as long as the header.
    task automatic test_register_extremes();
        load_config(16'd33, 16'h0000, 16'hFFFF);
        build_record(PAL_CLEAN);
        stream_record(1'b1, rec_len);
        load_config(16'd32, 16'hFFFF, 16'h0000);
        build_record(PAL_CLEAN);
        stream_record(1'b1, rec_len);
    endtask

    // Mostly well-formed short records with random payload, under randomly chosen
    // registers. The rest are records with flipped bits, records cut short by a new start,
    // and runs of noise. After a cut or noise, the next record starts with the start flag
    // so that it lines up again.
    task automatic test_random();
        int        first_word;
        int        pick;
        int        pos;
        t_rec_kind kind;
        logic      realign;
        first_word = words_sent;
        realign    = 1'b1;
        while (words_sent - first_word < RANDOM_WORDS) begin
            if (words_sent == first_word || $urandom_range(0, 9) == 0) begin
                load_config(16'($urandom_range(1, 48)), pick_register_value(),
                            pick_register_value());
            end
            pick = $urandom_range(0, 19);
            kind = (pick < 12) ? REC_CLEAN : (pick < 16) ? REC_SPOILED :
                   (pick < 18) ? REC_ABORTED : REC_NOISE;
            build_record(PAL_CLEAN);
            case (kind)
                REC_CLEAN: begin
                    stream_record(realign || ($urandom_range(0, 1) == 1), rec_len);
                    realign = 1'b0;
                end
                REC_SPOILED: begin
                    repeat ($urandom_range(1, 2)) begin
                        pos = ($urandom_range(0, 1) == 0)
                            ? $urandom_range(0, (rec_len < 32) ? rec_len - 1 : 31)
                            : $urandom_range(0, rec_len - 1);
                        rec_buf[pos] = rec_buf[pos] ^ 8'($urandom_range(1, 255));
                    end
                    stream_record(realign || ($urandom_range(0, 1) == 1), rec_len);
                    realign = 1'b0;
                end
                REC_ABORTED: begin
                    stream_record(1'b1, $urandom_range(1, rec_len));
                    realign = 1'b1;
                end
                default: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_word(8'($urandom), $urandom_range(0, 7) == 0);
                    end
                    realign = 1'b1;
                end
            endcase
        end
    endtask

    // The receiver switches between quiet stretches, short random stalls and long stalls.
    // The level for the next cycle is set at the falling edge.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        if (stall_left > 0) begin
            stall_left--;
        end else if (stall_mode == 1 && $urandom_range(0, 1) == 1) begin
            stall_left = $urandom_range(1, 3);
        end else if (stall_mode == 2 && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(5, 20);
        end
        i_out_stall <= (stall_left > 0);
    end

    // Each verdict that the block hands over is compared with the oldest one owed.
    always @(posedge i_clk) begin : check_verdict
        logic want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_due.size() == 0) begin
                $display("%0t: verdict %0b arrived but none was expected", $time, o_verdict);
                fail_count++;
            end else begin
                want = verdict_due.pop_front();
                if (o_verdict !== want) begin
                    $display("%0t: verdict mismatch, expected %0b, actual %0b",
                             $time, want, o_verdict);
                    fail_count++;
                end
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_data_byte       = 8'h00;
        i_start_of_record = 1'b0;
        i_out_stall       = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_RECORD_SIZE;
        i_cfg_data        = 16'h0000;
        restart_tracker();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_short_records();
        test_register_extremes();
        test_random();
        settle();

        if (fail_count == 0 && verdict_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (verdict_due.size() != 0) begin
                $display("%0t: %0d verdicts never arrived", $time, verdict_due.size());
            end
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/arv_pkg.sv
rtl/arv_hdr_check.sv
rtl/art_record_validator.sv
tb/tb_art_record_validator.sv
